FILE: hdl/lccp_pkg.sv
`timescale 1ns / 1ps

package lccp_pkg;

   // Default channel count of the lighting store
   localparam int CHANNELS_DEFAULT = 512;
   // Store index width; wide enough for the largest supported store (512 channels)
   localparam int ADDR_W = 9;
   // Entries in the queue between parser and executor
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int SYNC_STRIDE = 30;

   localparam logic [7:0] CODE_CONTROL_RESET = 8'd1;
   localparam logic [7:0] CODE_MULTI_RESET   = 8'd2;
   localparam logic [7:0] CODE_ONE_RESET     = 8'd3;
   localparam logic [7:0] CODE_SYNC_RESET    = 8'd4;
   localparam logic [7:0] CODE_CLEAR_RESET   = 8'd5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CODE_CONTROL = 3'd0,
      CSR_CODE_MULTI   = 3'd1,
      CSR_CODE_ONE     = 3'd2,
      CSR_CODE_SYNC    = 3'd3,
      CSR_CODE_CLEAR   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_IDLE      = 3'd0,
      KIND_CONTROL   = 3'd1,
      KIND_TRIPLES   = 3'd2,
      KIND_ONE_VALUE = 3'd3,
      KIND_SYNC      = 3'd4,
      KIND_CLEAR     = 3'd5,
      KIND_UNKNOWN   = 3'd6
   } kind_type;

   localparam logic COMMAND_PACKET = 1'b0;
   localparam logic COMMAND_READ   = 1'b1;
   localparam logic RESULT_STATUS  = 1'b0;
   localparam logic RESULT_READ    = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] packet_byte;
      logic       first_byte;
      logic [7:0] packet_length;
      logic [9:0] read_channel;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic       accepted;
      logic       running;
      logic [7:0] channel_value;
   } rsp_type;

   // One unit of work for the executor
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wr_data;
      logic              run_en;
      logic              run_value;
      logic              rsp_en;
      logic              rsp_kind;
      logic              accepted;
      logic              clear;
      logic              rd_hit;
   } op_type;

endpackage

FILE: hdl/lccp_front.sv
`timescale 1ns / 1ps

module lccp_front import lccp_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   input  req_type                req,
   input  logic                   fire,
   output op_type                 op,
   output logic                   op_any
);

   localparam logic [15:0] CH_MAX = 16'(CHANNELS);

   logic [7:0]  code_control_ff, code_multi_ff, code_one_ff, code_sync_ff, code_clear_ff;
   kind_type    kind_ff, kind_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  len_ff, len_in;
   logic        reject_ff, reject_in;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  high_ff, high_in;
   logic [12:0] wptr_ff, wptr_in;
   logic [1:0]  phase_ff, phase_in;

   kind_type    kind_new, kind_cur;
   logic        reject_cur, active;
   logic [7:0]  pos_cur, len_cur, b;
   logic [9:0]  list_end;
   logic [15:0] chan;
   logic        chan_we;
   logic [7:0]  chan_data;

   assign b = req.packet_byte;

   // Classify the code; on equal codes control wins, then multi, one, sync and clear
   always_comb begin
      kind_new = KIND_UNKNOWN;
      if (b == code_clear_ff)   kind_new = KIND_CLEAR;
      if (b == code_sync_ff)    kind_new = KIND_SYNC;
      if (b == code_one_ff)     kind_new = KIND_ONE_VALUE;
      if (b == code_multi_ff)   kind_new = KIND_TRIPLES;
      if (b == code_control_ff) kind_new = KIND_CONTROL;
   end

   always_comb begin
      op         = '0;
      kind_in    = kind_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      reject_in  = reject_ff;
      held_in    = held_ff;
      high_in    = high_ff;
      wptr_in    = wptr_ff;
      phase_in   = phase_ff;
      kind_cur   = kind_ff;
      reject_cur = reject_ff;
      pos_cur    = pos_ff;
      len_cur    = len_ff;
      active     = 1'b0;
      list_end   = '0;
      chan       = '0;
      chan_we    = 1'b0;
      chan_data  = '0;

      if (req.command == COMMAND_READ) begin
         op.rsp_en   = 1'b1;
         op.rsp_kind = RESULT_READ;
         op.rd_hit   = (req.read_channel != 10'd0) && ({6'd0, req.read_channel} <= CH_MAX);
         op.addr     = ADDR_W'(req.read_channel - 10'd1);
      end else if (req.first_byte) begin
         if (req.packet_length == 8'd0) begin
            kind_in     = KIND_IDLE;
            op.rsp_en   = 1'b1;
            op.rsp_kind = RESULT_STATUS;
         end else begin
            active     = 1'b1;
            kind_cur   = kind_new;
            pos_cur    = 8'd0;
            len_cur    = req.packet_length;
            reject_cur = (kind_new == KIND_UNKNOWN) ||
                         ((kind_new != KIND_CLEAR) && (req.packet_length < 8'd2));
         end
      end else if (kind_ff != KIND_IDLE) begin
         active  = 1'b1;
         pos_cur = pos_ff + 8'd1;
      end

      if (active) begin
         if (!reject_cur) begin
            if (pos_cur == 8'd1) begin
               phase_in = 2'd0;
               case (kind_cur)
                  KIND_CONTROL: begin
                     if (b == 8'd0 || b == 8'd1) begin
                        op.run_en    = 1'b1;
                        op.run_value = b[0];
                     end
                  end
                  KIND_TRIPLES: begin
                     list_end = {2'd0, b} + {1'b0, b, 1'b0} + 10'd2;
                     if ({2'd0, len_cur} < list_end) reject_cur = 1'b1;
                     else wptr_in = 13'(list_end);
                  end
                  KIND_ONE_VALUE: begin
                     list_end = {1'b0, b, 1'b0} + 10'd3;
                     if ({2'd0, len_cur} < list_end) reject_cur = 1'b1;
                     else wptr_in = 13'(list_end);
                  end
                  KIND_SYNC: begin
                     wptr_in = 13'(b) * 13'(SYNC_STRIDE) + 13'd1;
                  end
                  default: begin
                  end
               endcase
            end else if (pos_cur >= 8'd2) begin
               case (kind_cur)
                  KIND_TRIPLES: begin
                     phase_in = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
                     if ({5'd0, pos_cur} < wptr_ff) begin
                        case (phase_ff)
                           2'd0:    held_in = b;
                           2'd1:    high_in = b;
                           default: begin
                              chan      = {high_ff, b};
                              chan_we   = 1'b1;
                              chan_data = held_ff;
                           end
                        endcase
                     end
                  end
                  KIND_ONE_VALUE: begin
                     if (pos_cur == 8'd2) begin
                        held_in = b;
                     end else if ({5'd0, pos_cur} < wptr_ff) begin
                        if (pos_cur[0]) begin
                           high_in = b;
                        end else begin
                           chan      = {high_ff, b};
                           chan_we   = 1'b1;
                           chan_data = held_ff;
                        end
                     end
                  end
                  KIND_SYNC: begin
                     chan      = 16'(wptr_ff) + 16'(pos_cur) - 16'd2;
                     chan_we   = 1'b1;
                     chan_data = b;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Skip channels outside 1..CHANNELS
         if (chan_we && chan != 16'd0 && chan <= CH_MAX) begin
            op.wr_en   = 1'b1;
            op.addr    = ADDR_W'(chan - 16'd1);
            op.wr_data = chan_data;
         end

         pos_in    = pos_cur;
         len_in    = len_cur;
         reject_in = reject_cur;
         kind_in   = kind_cur;
         if ({1'b0, pos_cur} + 9'd1 >= {1'b0, len_cur}) begin
            kind_in     = KIND_IDLE;
            op.rsp_en   = 1'b1;
            op.rsp_kind = RESULT_STATUS;
            op.accepted = !reject_cur;
            op.clear    = !reject_cur && (kind_cur == KIND_CLEAR);
         end
      end
   end

   assign op_any = op.wr_en | op.run_en | op.rsp_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_control_ff <= CODE_CONTROL_RESET;
         code_multi_ff   <= CODE_MULTI_RESET;
         code_one_ff     <= CODE_ONE_RESET;
         code_sync_ff    <= CODE_SYNC_RESET;
         code_clear_ff   <= CODE_CLEAR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CODE_CONTROL: code_control_ff <= csr_wdata;
            CSR_CODE_MULTI:   code_multi_ff   <= csr_wdata;
            CSR_CODE_ONE:     code_one_ff     <= csr_wdata;
            CSR_CODE_SYNC:    code_sync_ff    <= csr_wdata;
            CSR_CODE_CLEAR:   code_clear_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_IDLE;
         pos_ff    <= '0;
         len_ff    <= '0;
         reject_ff <= 1'b0;
      end else if (fire) begin
         kind_ff   <= kind_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         reject_ff <= reject_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         held_ff  <= held_in;
         high_ff  <= high_in;
         wptr_ff  <= wptr_in;
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: hdl/lccp_queue.sv
`timescale 1ns / 1ps

module lccp_queue import lccp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output op_type head_op,
   output logic   not_empty,
   output logic   full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   op_type          slots_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;

   assign head_op   = slots_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CW'(DEPTH));

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

FILE: hdl/lccp_back.sv
`timescale 1ns / 1ps

module lccp_back import lccp_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  op_type  op,
   input  logic    op_valid,
   output logic    op_pop,
   output logic    init_busy,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [7:0]    store_mem [CHANNELS];
   logic          sweeping_ff, init_ff;
   logic [AW-1:0] sweep_cnt_ff;
   logic          run_flag_ff;
   logic          rsp_valid_ff;
   logic          rsp_kind_ff, accepted_ff, running_ff, hit_ff;
   logic [7:0]    rd_data_ff;
   logic          take_rsp;

   // Hold ops with a result while the output register is still full
   assign op_pop   = op_valid && !sweeping_ff && (!op.rsp_en || !rsp_valid_ff || rsp_ready);
   assign take_rsp = op_pop && op.rsp_en;

   always_ff @(posedge clock) begin
      if (sweeping_ff) begin
         store_mem[sweep_cnt_ff] <= 8'd0;
      end else if (op_pop && op.wr_en) begin
         store_mem[op.addr[AW-1:0]] <= op.wr_data;
      end
      if (take_rsp && op.rsp_kind == RESULT_READ) rd_data_ff <= store_mem[op.addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweeping_ff  <= 1'b1;
         init_ff      <= 1'b1;
         sweep_cnt_ff <= '0;
         run_flag_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (sweeping_ff) begin
            if (sweep_cnt_ff == AW'(CHANNELS - 1)) begin
               sweeping_ff  <= 1'b0;
               init_ff      <= 1'b0;
               sweep_cnt_ff <= '0;
            end else begin
               sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
            end
         end
         if (op_pop && op.clear) sweeping_ff <= 1'b1;
         if (op_pop && op.run_en) run_flag_ff <= op.run_value;
         if (take_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_rsp) begin
         rsp_kind_ff <= op.rsp_kind;
         accepted_ff <= op.accepted;
         running_ff  <= op.run_en ? op.run_value : run_flag_ff;
         hit_ff      <= op.rd_hit;
      end
   end

   assign init_busy                 = init_ff;
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_payload.result_kind   = rsp_kind_ff;
   assign rsp_payload.accepted      = accepted_ff;
   assign rsp_payload.running       = running_ff;
   assign rsp_payload.channel_value = hit_ff ? rd_data_ff : 8'd0;

endmodule

FILE: hdl/lighting_channel_command_parser.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_payload (req_type)
// rsp       out        rsp_valid/rsp_ready    rsp_payload (rsp_type)
// csr       in         csr_we                 csr_index, csr_wdata (8 bits)
//
// One transfer per cycle on req while the parser-to-executor queue has room and the store is ready.
// A read result passes through a queue slot and then the result register before it leaves.
// After reset the store is zeroed by a pass over all CHANNELS entries (512 by default);
// req_ready stays low for that pass, csr writes are taken throughout.
// A clear packet holds the executor while it zeroes every channel; the queue then fills
// and req_ready drops until the pass ends.

module lighting_channel_command_parser import lccp_pkg::*; #(
   parameter int CHANNELS    = CHANNELS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   op_type front_op, head_op;
   logic   op_any, fire, q_not_empty, q_full, pop, init_busy;

   // Accept a transfer whenever the queue can take its op and the store is ready
   assign req_ready = !q_full && !init_busy;
   assign fire      = req_valid && req_ready;

   // Front: classify bytes, track the packet, turn each byte into one op
   lccp_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_payload),
      .fire      (fire),
      .op        (front_op),
      .op_any    (op_any)
   );

   // Queue: decouple parsing from store access; drop ops that do nothing
   lccp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire && op_any),
      .push_op   (front_op),
      .pop       (pop),
      .head_op   (head_op),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // Back: store writes, reads, run flag, clearing pass and the result register
   lccp_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .op          (head_op),
      .op_valid    (q_not_empty),
      .op_pop      (pop),
      .init_busy   (init_busy),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: tb/sv/lighting_channel_command_parser_test.sv
`timescale 1ns / 1ps

module lighting_channel_command_parser_test;
   import lccp_pkg::*;

   localparam int CHANNEL_COUNT = CHANNELS_DEFAULT;
   // Covers one clear pass of the store plus the queue and output stages
   localparam int SETTLE_CYCLES = CHANNEL_COUNT + 88;
   localparam int CYCLE_LIMIT   = 400000;
   // The receiver stops once, after this many results, for this long
   localparam int HOLD_AT       = 100;
   localparam int HOLD_CYCLES   = 300;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_payload = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_CODE_CONTROL;
   logic [7:0]    csr_wdata = 8'd0;

   lighting_channel_command_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Parser shadow: command codes, channel levels, run flag and packet state.
   // Updated once per accepted transfer, in transfer order.
   // ---------------------------------------------------------------------------
   logic [7:0]  cmd_code [5];
   logic [7:0]  dim_level [1:CHANNEL_COUNT];
   logic        run_on;
   logic [7:0]  byte_pos;
   logic [7:0]  pkt_len;
   kind_type    pkt_kind;
   logic        pkt_bad;
   logic [7:0]  level_held;
   logic [7:0]  chan_high;
   logic [15:0] list_end;       // end position for lists, first channel for sync

   rsp_type     pending_replies [$];
   req_type     outgoing_req [$];
   logic [7:0]  frame [$];      // packet under construction
   logic [7:0]  next_code [5];

   int          items_queued = 0;
   int          results_seen = 0;
   int          errors = 0;
   int          cycle_count;
   bit          quiet = 1'b0;   // no idling on either side once set
   int          send_gap = 0;
   int          drain_gap = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;

   function automatic void set_level(int ch, logic [7:0] v);
      // drop writes to channel 0 and anything past the top of the store
      if (ch >= 1 && ch <= CHANNEL_COUNT)
         dim_level[ch] = v;
   endfunction

   function automatic void apply_data_byte(int pos, logic [7:0] b);
      int stop;
      if (pos == 1) begin
         // byte 1 decides validity of the whole packet
         case (pkt_kind)
            KIND_CONTROL: begin
               if (b == 8'd0)
                  run_on = 1'b0;
               else if (b == 8'd1)
                  run_on = 1'b1;
            end
            KIND_TRIPLES: begin
               stop = 2 + 3 * b;
               if (pkt_len < stop)
                  pkt_bad = 1'b1;
               else
                  list_end = 16'(stop);
            end
            KIND_ONE_VALUE: begin
               stop = 3 + 2 * b;
               if (pkt_len < stop)
                  pkt_bad = 1'b1;
               else
                  list_end = 16'(stop);
            end
            KIND_SYNC: begin
               list_end = 16'(b * SYNC_STRIDE + 1);
            end
            default: ;
         endcase
      end else if (pos >= 2) begin
         case (pkt_kind)
            KIND_TRIPLES: begin
               // value, channel high, channel low; ignore bytes past the list
               if (pos < list_end) begin
                  case ((pos - 2) % 3)
                     0: level_held = b;
                     1: chan_high = b;
                     default: set_level({chan_high, b}, level_held);
                  endcase
               end
            end
            KIND_ONE_VALUE: begin
               if (pos == 2)
                  level_held = b;
               else if (pos < list_end) begin
                  if (((pos - 3) & 1) == 0)
                     chan_high = b;
                  else
                     set_level({chan_high, b}, level_held);
               end
            end
            KIND_SYNC: begin
               set_level(list_end + pos - 2, b);
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void absorb_transfer(req_type r);
      rsp_type reply;
      int      pos;
      reply = '0;
      if (r.command == COMMAND_READ) begin
         // served at once, the packet in progress is left alone
         reply.result_kind = RESULT_READ;
         reply.running = run_on;
         if (r.read_channel >= 1 && r.read_channel <= CHANNEL_COUNT)
            reply.channel_value = dim_level[r.read_channel];
         pending_replies.push_back(reply);
         return;
      end
      if (r.first_byte) begin
         if (r.packet_length == 8'd0) begin
            // zero length: immediate reject, stay idle
            pkt_kind = KIND_IDLE;
            reply.result_kind = RESULT_STATUS;
            reply.running = run_on;
            pending_replies.push_back(reply);
            return;
         end
         // a new packet abandons any unfinished one without a status
         pkt_len = r.packet_length;
         byte_pos = 8'd0;
         pkt_bad = 1'b0;
         // equal codes: the earliest command in the list wins
         if (r.packet_byte == cmd_code[CSR_CODE_CONTROL])
            pkt_kind = KIND_CONTROL;
         else if (r.packet_byte == cmd_code[CSR_CODE_MULTI])
            pkt_kind = KIND_TRIPLES;
         else if (r.packet_byte == cmd_code[CSR_CODE_ONE])
            pkt_kind = KIND_ONE_VALUE;
         else if (r.packet_byte == cmd_code[CSR_CODE_SYNC])
            pkt_kind = KIND_SYNC;
         else if (r.packet_byte == cmd_code[CSR_CODE_CLEAR])
            pkt_kind = KIND_CLEAR;
         else
            pkt_kind = KIND_UNKNOWN;
         if (pkt_kind == KIND_UNKNOWN || (pkt_kind != KIND_CLEAR && r.packet_length < 8'd2))
            pkt_bad = 1'b1;
      end else begin
         // stray byte while idle: no effect, no result
         if (pkt_kind == KIND_IDLE)
            return;
         byte_pos = byte_pos + 8'd1;
      end
      pos = byte_pos;
      if (!pkt_bad)
         apply_data_byte(pos, r.packet_byte);
      if (pos + 1 >= pkt_len) begin
         if (!pkt_bad && pkt_kind == KIND_CLEAR)
            foreach (dim_level[c])
               dim_level[c] = 8'd0;
         pkt_kind = KIND_IDLE;
         reply.result_kind = RESULT_STATUS;
         reply.accepted = !pkt_bad;
         reply.running = run_on;
         pending_replies.push_back(reply);
      end
   endfunction

   function automatic void check_result(rsp_type got);
      rsp_type want;
      results_seen++;
      if (pending_replies.size() == 0) begin
         $display("%0t: result %h arrived with nothing expected", $time, got);
         errors++;
         return;
      end
      want = pending_replies.pop_front();
      if (got.result_kind !== want.result_kind) begin
         $display("%0t: result_kind expected %h actual %h", $time, want.result_kind,
                  got.result_kind);
         errors++;
      end
      if (got.accepted !== want.accepted) begin
         $display("%0t: accepted expected %h actual %h", $time, want.accepted, got.accepted);
         errors++;
      end
      if (got.running !== want.running) begin
         $display("%0t: running expected %h actual %h", $time, want.running, got.running);
         errors++;
      end
      if (got.channel_value !== want.channel_value) begin
         $display("%0t: channel_value expected %h actual %h", $time, want.channel_value,
                  got.channel_value);
         errors++;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus builders. Fields the block ignores for a given item are randomized
   // so that every input bit toggles.
   // ---------------------------------------------------------------------------
   function automatic void enqueue(req_type it);
      outgoing_req.push_back(it);
      items_queued++;
   endfunction

   function automatic req_type packet_item(logic [7:0] b, logic is_first, logic [7:0] len);
      req_type it;
      it.command = COMMAND_PACKET;
      it.packet_byte = b;
      it.first_byte = is_first;
      it.packet_length = is_first ? len : 8'($urandom);
      it.read_channel = 10'($urandom);
      return it;
   endfunction

   function automatic req_type read_item(logic [9:0] ch);
      req_type it;
      it.command = COMMAND_READ;
      it.packet_byte = 8'($urandom);
      it.first_byte = 1'($urandom);
      it.packet_length = 8'($urandom);
      it.read_channel = ch;
      return it;
   endfunction

   function automatic logic [9:0] pick_read_channel();
      case ($urandom_range(0, 9))
         0: return 10'd0;
         1: return 10'($urandom_range(CHANNEL_COUNT + 1, 1023));
         default: return 10'($urandom_range(1, CHANNEL_COUNT));
      endcase
   endfunction

   function automatic logic [15:0] pick_write_channel();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return ($urandom_range(0, 1) == 0) ? 16'd0 : 16'(CHANNEL_COUNT + 1);
         default: return 16'($urandom_range(1, CHANNEL_COUNT));
      endcase
   endfunction

   function automatic logic [7:0] unused_code();
      logic [7:0] c;
      do
         c = 8'($urandom);
      while (c == cmd_code[CSR_CODE_CONTROL] || c == cmd_code[CSR_CODE_MULTI] ||
             c == cmd_code[CSR_CODE_ONE] || c == cmd_code[CSR_CODE_SYNC] ||
             c == cmd_code[CSR_CODE_CLEAR]);
      return c;
   endfunction

   // Send the first 'emit' bytes of the frame, padded at random up to 'len', with random reads if asked
   function automatic void put_packet(int len, int emit, bit with_reads);
      while (frame.size() < len)
         frame.push_back(8'($urandom));
      for (int i = 0; i < emit; i++) begin
         enqueue(packet_item(frame[i], i == 0, 8'(len)));
         if (with_reads && $urandom_range(0, 7) == 0)
            enqueue(read_item(pick_read_channel()));
      end
   endfunction

   function automatic void add_random_packet();
      int         pick;
      int         count;
      int         len;
      int         emit;
      logic [15:0] ch;
      frame.delete();
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         // zero length first byte
         enqueue(packet_item(8'($urandom), 1'b1, 8'd0));
         return;
      end
      if (pick < 6) begin
         // byte without a first marker
         enqueue(packet_item(8'($urandom), 1'b0, 8'd0));
         return;
      end
      if (pick < 9) begin
         frame.push_back(cmd_code[CSR_CODE_CLEAR]);
      end else if (pick < 16) begin
         frame.push_back(unused_code());
         repeat ($urandom_range(0, 4))
            frame.push_back(8'($urandom));
      end else if (pick < 31) begin
         frame.push_back(cmd_code[CSR_CODE_CONTROL]);
         frame.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, 1)));
      end else if (pick < 56) begin
         count = ($urandom_range(0, 40) == 0) ? 84 : $urandom_range(0, 4);
         frame.push_back(cmd_code[CSR_CODE_MULTI]);
         frame.push_back(8'(count));
         repeat (count) begin
            ch = pick_write_channel();
            frame.push_back(8'($urandom));
            frame.push_back(ch[15:8]);
            frame.push_back(ch[7:0]);
         end
      end else if (pick < 76) begin
         count = ($urandom_range(0, 40) == 0) ? 126 : $urandom_range(0, 5);
         frame.push_back(cmd_code[CSR_CODE_ONE]);
         frame.push_back(8'(count));
         frame.push_back(8'($urandom));
         repeat (count) begin
            ch = pick_write_channel();
            frame.push_back(ch[15:8]);
            frame.push_back(ch[7:0]);
         end
      end else begin
         // sync: mostly starting inside the store, some past its end
         frame.push_back(cmd_code[CSR_CODE_SYNC]);
         if ($urandom_range(0, 40) == 0) begin
            frame.push_back(8'd0);
            count = 253;
         end else begin
            frame.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 17)));
            count = $urandom_range(0, 8);
         end
         repeat (count)
            frame.push_back(8'($urandom));
      end
      len = frame.size();
      if ($urandom_range(0, 3) == 0)
         len = len + $urandom_range(1, 3);
      if (len > 255)
         len = 255;
      emit = len;
      case ($urandom_range(0, 11))
         0: begin
            // declared length too short for the body
            if (frame.size() > 1) begin
               len = $urandom_range(1, frame.size() - 1);
               emit = len;
            end
         end
         1: begin
            // cut short, the next first byte abandons it
            if (len > 1)
               emit = $urandom_range(1, len - 1);
         end
         default: ;
      endcase
      put_packet(len, emit, 1'b1);
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: present one item at a time from outgoing_req, hold it until the
   // transfer, and feed every transfer to the shadow in order.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            absorb_transfer(req_payload);
         // only a free slot may idle or advance; otherwise hold the payload
         if (!req_valid || req_ready) begin
            if (send_gap == 0 && !quiet && $urandom_range(0, 9) == 0)
               send_gap = $urandom_range(1, 11);
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (outgoing_req.size() != 0) begin
               req_valid <= 1'b1;
               req_payload <= outgoing_req.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: check each result transfer and drive rsp_ready with random stalls,
   // plus one long hold-off that backs the block up into its input.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_result(rsp_payload);
         if (hold_left == 0 && !hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left == 0 && drain_gap == 0 && !quiet && $urandom_range(0, 9) == 0)
            drain_gap = $urandom_range(1, 11);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (drain_gap > 0) begin
            drain_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Wait until every queued item is transferred and every result is back
   task automatic wait_idle();
      do
         @(negedge clock);
      while (outgoing_req.size() != 0 || req_valid || pending_replies.size() != 0);
   endtask

   // Drain, let a possible clear pass finish, then write all five codes
   task automatic program_codes();
      csr_index_type idx;
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      idx = CSR_CODE_CONTROL;
      repeat (5) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= idx;
         csr_wdata <= next_code[idx];
         cmd_code[idx] = next_code[idx];
         idx = idx.next();
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic stream_random(int n);
      int target;
      @(negedge clock);
      target = items_queued + n;
      while (items_queued < target)
         add_random_packet();
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout with %0d results outstanding", $time, pending_replies.size());
      $display("lighting_channel_command_parser_test failed");
      $finish;
   end

   initial begin
      int base;
      int step;
      // shadow starts from the reset state
      cmd_code[CSR_CODE_CONTROL] = CODE_CONTROL_RESET;
      cmd_code[CSR_CODE_MULTI] = CODE_MULTI_RESET;
      cmd_code[CSR_CODE_ONE] = CODE_ONE_RESET;
      cmd_code[CSR_CODE_SYNC] = CODE_SYNC_RESET;
      cmd_code[CSR_CODE_CLEAR] = CODE_CLEAR_RESET;
      foreach (dim_level[c])
         dim_level[c] = 8'd0;
      run_on = 1'b0;
      byte_pos = 8'd0;
      pkt_len = 8'd0;
      pkt_kind = KIND_IDLE;
      pkt_bad = 1'b0;
      level_held = 8'd0;
      chan_high = 8'd0;
      list_end = 16'd0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: read out of range, zero length, stray byte, start,
      // unknown code, too-short control, top channel via triples, channel 0
      // via one value, sync up to the top channel with a read inside it, clear.
      enqueue(read_item(10'd0));
      enqueue(packet_item(cmd_code[CSR_CODE_CONTROL], 1'b1, 8'd0));
      enqueue(packet_item(8'hA5, 1'b0, 8'd0));
      frame = {cmd_code[CSR_CODE_CONTROL], 8'd1};
      put_packet(2, 2, 1'b0);
      frame = {8'hFF, 8'd0};
      put_packet(2, 2, 1'b0);
      frame = {cmd_code[CSR_CODE_CONTROL]};
      put_packet(1, 1, 1'b0);
      frame = {cmd_code[CSR_CODE_MULTI], 8'd1, 8'hFF, 8'h02, 8'h00};
      put_packet(5, 5, 1'b0);
      enqueue(read_item(10'(CHANNEL_COUNT)));
      frame = {cmd_code[CSR_CODE_ONE], 8'd1, 8'h5A, 8'h00, 8'h00};
      put_packet(5, 5, 1'b0);
      enqueue(packet_item(cmd_code[CSR_CODE_SYNC], 1'b1, 8'd4));
      enqueue(packet_item(8'd17, 1'b0, 8'd0));
      enqueue(packet_item(8'h11, 1'b0, 8'd0));
      enqueue(read_item(10'(CHANNEL_COUNT)));
      enqueue(packet_item(8'h22, 1'b0, 8'd0));
      frame = {cmd_code[CSR_CODE_CLEAR]};
      put_packet(1, 1, 1'b0);

      stream_random(250);

      // all codes zero: every packet with code zero decodes as control
      foreach (next_code[i])
         next_code[i] = 8'h00;
      program_codes();
      stream_random(200);

      // all codes at the top of the range
      foreach (next_code[i])
         next_code[i] = 8'hFF;
      program_codes();
      stream_random(200);

      // distinct random codes: odd stride keeps them apart
      base = $urandom_range(0, 255);
      step = 2 * $urandom_range(0, 25) + 1;
      foreach (next_code[i])
         next_code[i] = 8'(base + i * step);
      program_codes();
      stream_random(200);

      // heavy overlap among three values
      foreach (next_code[i])
         next_code[i] = 8'h80 + 8'($urandom_range(0, 2));
      program_codes();
      stream_random(200);

      // back to the reset codes, with no idling on either side
      next_code[CSR_CODE_CONTROL] = CODE_CONTROL_RESET;
      next_code[CSR_CODE_MULTI] = CODE_MULTI_RESET;
      next_code[CSR_CODE_ONE] = CODE_ONE_RESET;
      next_code[CSR_CODE_SYNC] = CODE_SYNC_RESET;
      next_code[CSR_CODE_CLEAR] = CODE_CLEAR_RESET;
      program_codes();
      @(negedge clock);
      quiet = 1'b1;
      stream_random(120);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("lighting_channel_command_parser_test passed");
      else
         $display("lighting_channel_command_parser_test failed");
      $finish;
   end

endmodule
